// ===== design/mac_pkg.sv =====
// shared types and constants of the moving average crossover unit
`default_nettype none

package mac_pkg;

    localparam int PRICE_W    = 32;
    localparam int FAST_W     = 6;
    localparam int SLOW_W     = 7;
    localparam int MARGIN_W   = 32;
    localparam int LPROD_W    = FAST_W + SLOW_W;
    localparam int BAND_W     = MARGIN_W + LPROD_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_W      = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FAST_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN   = 2'd2;

    localparam logic [FAST_W-1:0]   RST_FAST_LEN = 6'd2;
    localparam logic [SLOW_W-1:0]   RST_SLOW_LEN = 7'd3;
    localparam logic [MARGIN_W-1:0] RST_MARGIN   = 32'd66;
    localparam logic [LPROD_W-1:0]  RST_LPROD    = 13'd6;
    localparam logic [BAND_W-1:0]   RST_BAND     = 45'd396;

    // cycles the input stays closed after a configuration write
    localparam logic [1:0] CFG_SETTLE = 2'd2;

    typedef enum logic [1:0] {
        SIG_HOLD = 2'd0,
        SIG_BUY  = 2'd1,
        SIG_SELL = 2'd2
    } signal_t;

    // packed so that signal sits in the lowest bits of the output word
    typedef struct packed {
        logic    config_error;
        logic    warming;
        signal_t signal;
    } result_t;

endpackage

`default_nettype wire

// ===== design/mac_hist.sv =====
// price history memory, one write and two registered read ports with write bypass
`default_nettype none

module mac_hist #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_a_reg;
    logic [DATA_W-1:0] rd_b_reg;
    logic [DATA_W-1:0] wdata_reg;
    logic              hit_a_reg;
    logic              hit_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg  <= mem[raddr_a];
        rd_b_reg  <= mem[raddr_b];
        hit_a_reg <= we && (waddr == raddr_a);
        hit_b_reg <= we && (waddr == raddr_b);
        wdata_reg <= wdata;
    end

    // a read that collided with the write returns the new word
    assign rdata_a = hit_a_reg ? wdata_reg : rd_a_reg;
    assign rdata_b = hit_b_reg ? wdata_reg : rd_b_reg;

endmodule

`default_nettype wire

// ===== design/mac_decide.sv =====
// exact comparison of the two means by cross-multiplication
`default_nettype none

module mac_decide #(
    parameter int SUM_W = 38
) (
    input  logic [SUM_W-1:0]           fast_sum,
    input  logic [SUM_W-1:0]           slow_sum,
    input  logic [mac_pkg::FAST_W-1:0] fast_len,
    input  logic [mac_pkg::SLOW_W-1:0] slow_len,
    input  logic [mac_pkg::BAND_W-1:0] band,
    input  logic                       enable,
    output mac_pkg::signal_t           signal
);

    import mac_pkg::*;

    localparam int PROD_W = ((SUM_W + SLOW_W > BAND_W) ? SUM_W + SLOW_W : BAND_W) + 1;

    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;
    logic [PROD_W-1:0] band_x;

    assign lhs    = PROD_W'(fast_sum) * PROD_W'(slow_len);
    assign rhs    = PROD_W'(slow_sum) * PROD_W'(fast_len);
    assign band_x = PROD_W'(band);

    always_comb
    begin
        priority if (!enable)
        begin
            signal = SIG_HOLD;
        end
        else if (lhs > rhs + band_x)
        begin
            signal = SIG_BUY;
        end
        else if (lhs + band_x < rhs)
        begin
            signal = SIG_SELL;
        end
        else
        begin
            signal = SIG_HOLD;
        end
    end

endmodule

`default_nettype wire

// ===== design/moving_average_crossover_unit.sv =====
// top level: dual moving average crossover signal unit
// an accepted price word is held in the input register, its result word in the output register
// throughput: one word per cycle unless m_tready stalls it; sum update and compare are a single pass
// a configuration write closes the input while the band product settles into band_reg
// reset: asynchronous, active low; windows return to 2 and 3, margin to 66, history empty
// the input also stays closed after reset until settle_reg counts down to zero
`default_nettype none

module moving_average_crossover_unit #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mac_pkg::PRICE_W-1:0]    s_tdata,    // price[31:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mac_pkg::OUT_W-1:0]      m_tdata,    // signal[1:0], warming[2], config_error[3]
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mac_pkg::CFG_DATA_W-1:0] cfg_data
);

    import mac_pkg::*;

    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = PRICE_W + PTR_W;
    localparam int LEN_W = ((CNT_W > SLOW_W) ? CNT_W : SLOW_W) + 1;
    localparam int ADR_W = ((PTR_W > SLOW_W) ? PTR_W : SLOW_W) + 1;
    localparam logic [ADR_W-1:0] MAX_A   = ADR_W'(MAX_WINDOW);
    localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(MAX_WINDOW - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WINDOW);

    // configuration and derived values
    logic [FAST_W-1:0]   fast_len_reg, fast_len_next;
    logic [SLOW_W-1:0]   slow_len_reg, slow_len_next;
    logic [MARGIN_W-1:0] margin_reg, margin_next;
    logic [LPROD_W-1:0]  lprod_reg;
    logic [BAND_W-1:0]   band_reg;
    logic                err_reg, err_next;
    logic [1:0]          settle_reg;
    logic                clear;

    // history state
    logic [PTR_W-1:0] wp_reg, wp_next, wp_upd;
    logic [CNT_W-1:0] fill_reg, fill_next, fill_upd;
    logic [SUM_W-1:0] fast_sum_reg, fast_sum_next, fast_sum_upd;
    logic [SUM_W-1:0] slow_sum_reg, slow_sum_next, slow_sum_upd;

    // pipeline
    logic               in_v_reg;
    logic [PRICE_W-1:0] price_reg;
    logic               out_v_reg;
    result_t            out_reg;
    result_t            res;
    logic               fire;
    logic               store;
    logic               warm;
    logic               cmp_en;
    signal_t            dec_sig;

    logic [PTR_W-1:0]   ra_fast, ra_slow;
    logic [PRICE_W-1:0] old_fast, old_slow;
    logic [LEN_W-1:0]   fill_ext, fast_ext, slow_ext;

    // slot holding the price pushed 'back' writes before pointer p
    function automatic logic [PTR_W-1:0] slot_back(input logic [PTR_W-1:0] p,
                                                   input logic [SLOW_W-1:0] back);
        logic [ADR_W-1:0] t;
        t = ADR_W'(p);
        if (ADR_W'(back) > t)
        begin
            t = t + MAX_A;
        end
        t = t - ADR_W'(back);
        if (t >= MAX_A)
        begin
            t = '0;
        end
        return t[PTR_W-1:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign fire      = in_v_reg && (!out_v_reg || m_tready);
    assign s_tready  = (!in_v_reg || fire) && (settle_reg == '0);
    assign m_tvalid  = out_v_reg;
    assign m_tdata   = OUT_W'(out_reg);

    always_comb
    begin
        fast_len_next = fast_len_reg;
        slow_len_next = slow_len_reg;
        margin_next   = margin_reg;
        clear         = 1'b0;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FAST_LEN:
                begin
                    fast_len_next = cfg_data[FAST_W-1:0];
                    clear         = 1'b1;
                end
                REG_SLOW_LEN:
                begin
                    slow_len_next = cfg_data[SLOW_W-1:0];
                    clear         = 1'b1;
                end
                REG_MARGIN:
                begin
                    margin_next = cfg_data[MARGIN_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign err_next = (fast_len_next == '0)
                   || (SLOW_W'(fast_len_next) >= slow_len_next)
                   || (ADR_W'(slow_len_next) > MAX_A);

    // sum update for the word in the input register
    assign store    = fire && !err_reg && (price_reg != '0);
    assign fill_ext = LEN_W'(fill_reg);
    assign fast_ext = LEN_W'(fast_len_reg);
    assign slow_ext = LEN_W'(slow_len_reg);

    assign fast_sum_upd = fast_sum_reg
                        - ((fill_ext >= fast_ext) ? SUM_W'(old_fast) : '0)
                        + SUM_W'(price_reg);
    assign slow_sum_upd = slow_sum_reg
                        - ((fill_ext >= slow_ext) ? SUM_W'(old_slow) : '0)
                        + SUM_W'(price_reg);
    assign fill_upd = (fill_reg < CNT_MAX) ? fill_reg + 1'b1 : fill_reg;
    assign wp_upd   = (wp_reg == PTR_TOP) ? '0 : wp_reg + 1'b1;

    always_comb
    begin
        priority if (clear)
        begin
            wp_next       = '0;
            fill_next     = '0;
            fast_sum_next = '0;
            slow_sum_next = '0;
        end
        else if (store)
        begin
            wp_next       = wp_upd;
            fill_next     = fill_upd;
            fast_sum_next = fast_sum_upd;
            slow_sum_next = slow_sum_upd;
        end
        else
        begin
            wp_next       = wp_reg;
            fill_next     = fill_reg;
            fast_sum_next = fast_sum_reg;
            slow_sum_next = slow_sum_reg;
        end
    end

    // leaving prices are fetched in the cycle before they are needed, from the state the next word will see
    assign ra_fast = slot_back(wp_next, SLOW_W'(fast_len_next));
    assign ra_slow = slot_back(wp_next, slow_len_next);

    mac_hist #(
        .DEPTH  (MAX_WINDOW),
        .ADDR_W (PTR_W),
        .DATA_W (PRICE_W)
    ) u_hist (
        .clk     (clk),
        .we      (store),
        .waddr   (wp_reg),
        .wdata   (price_reg),
        .raddr_a (ra_fast),
        .raddr_b (ra_slow),
        .rdata_a (old_fast),
        .rdata_b (old_slow)
    );

    assign warm   = LEN_W'(store ? fill_upd : fill_reg) < slow_ext;
    assign cmp_en = store && !warm;

    mac_decide #(
        .SUM_W (SUM_W)
    ) u_decide (
        .fast_sum (fast_sum_upd),
        .slow_sum (slow_sum_upd),
        .fast_len (fast_len_reg),
        .slow_len (slow_len_reg),
        .band     (band_reg),
        .enable   (cmp_en),
        .signal   (dec_sig)
    );

    always_comb
    begin
        if (err_reg)
        begin
            res.config_error = 1'b1;
            res.warming      = 1'b0;
            res.signal       = SIG_HOLD;
        end
        else
        begin
            res.config_error = 1'b0;
            res.warming      = warm;
            res.signal       = dec_sig;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_len_reg <= RST_FAST_LEN;
            slow_len_reg <= RST_SLOW_LEN;
            margin_reg   <= RST_MARGIN;
            lprod_reg    <= RST_LPROD;
            band_reg     <= RST_BAND;
            err_reg      <= 1'b0;
            settle_reg   <= CFG_SETTLE;
            wp_reg       <= '0;
            fill_reg     <= '0;
            fast_sum_reg <= '0;
            slow_sum_reg <= '0;
            in_v_reg     <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            fast_len_reg <= fast_len_next;
            slow_len_reg <= slow_len_next;
            margin_reg   <= margin_next;
            lprod_reg    <= LPROD_W'(fast_len_next) * LPROD_W'(slow_len_next);
            band_reg     <= BAND_W'(margin_reg) * BAND_W'(lprod_reg);
            err_reg      <= err_next;
            if (cfg_valid)
            begin
                settle_reg <= CFG_SETTLE;
            end
            else if (settle_reg != '0)
            begin
                settle_reg <= settle_reg - 1'b1;
            end
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            fast_sum_reg <= fast_sum_next;
            slow_sum_reg <= slow_sum_next;
            if (s_tvalid && s_tready)
            begin
                in_v_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_v_reg <= 1'b0;
            end
            if (fire)
            begin
                out_v_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            price_reg <= s_tdata;
        end
        if (fire)
        begin
            out_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ===== design/mac_chk.sv =====
// port-level checks of the moving average crossover unit, bound to the top level
`default_nettype none

module mac_chk (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [mac_pkg::OUT_W-1:0] m_tdata,
    input logic                      cfg_valid,
    input logic                      cfg_ready
);

    import mac_pkg::*;

    result_t res;

    assign res = result_t'(m_tdata[$bits(result_t)-1:0]);

    // a bad window setting always holds and never reports warming
    a_err_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.config_error |-> res.signal == SIG_HOLD && !res.warming)
        else $error("config error word carries a trade signal or warming");

    // no trade before the slow window is full
    a_warm_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.warming |-> res.signal == SIG_HOLD)
        else $error("trade signal while warming");

    // input closes after a configuration write
    a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !s_tready)
        else $error("input open right after a configuration write");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

endmodule

bind moving_average_crossover_unit mac_chk u_mac_chk (.*);

`default_nettype wire
